@@ rtl/tit_pkg.sv @@
// Shared types and constants for the timer table.
// Used by tit_cell, tit_chain and timeout_interval_timer_table; depends on nothing.
package tit_pkg;

   // Command codes of an input transaction.
   localparam logic [1:0] CMD_SCHEDULE = 2'd0;
   localparam logic [1:0] CMD_CLEAR    = 2'd1;
   localparam logic [1:0] CMD_TICK     = 2'd2;

   // Event kinds of a result transaction.
   localparam logic [1:0] EVT_ASSIGNED = 2'd0;
   localparam logic [1:0] EVT_FIRED    = 2'd1;
   localparam logic [1:0] EVT_REJECTED = 2'd2;

   // A single tick reports at most this many fired timers.
   localparam int FIRE_W = 5;
   localparam logic [FIRE_W-1:0] MAX_RESULTS = 5'd16;

   // Input transaction payload.
   typedef struct packed {
      logic [1:0]  cmd;
      logic [31:0] duration_ms;
      logic        repeat_flag;
      logic [31:0] target_id;
   } req_type;

   // Result transaction payload.
   typedef struct packed {
      logic [1:0]  event_kind;
      logic [31:0] event_id;
      logic        last_of_run;
   } rsp_type;

   // Payload of one timer entry.
   typedef struct packed {
      logic [31:0] ident;
      logic [31:0] period;
      logic [47:0] due;
      logic        periodic;
   } slot_type;

   // Operation applied to the whole row of cells at once.
   typedef struct packed {
      logic shift;    // every cell takes its upper neighbor's entry
      logic compact;  // entries slide down into empty cells
      logic write;    // the selected cell loads a new entry
   } chain_ctrl_type;

   // Sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PASS,
      ST_COMPACT,
      ST_FLUSH
   } state_type;

endpackage

@@ rtl/tit_cell.sv @@
// One cell of the timer row: holds a single timer entry and its valid bit.
// Depends on tit_pkg for the entry and control types.
module tit_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  tit_pkg::chain_ctrl_type ctrl,
   input  logic                    wr_sel,
   input  tit_pkg::slot_type       wr_slot,
   input  logic                    up_valid,
   input  tit_pkg::slot_type       up_slot,
   input  logic                    low_valid,
   output logic                    cur_valid,
   output tit_pkg::slot_type       cur_slot,
   output logic                    gap
);

   logic              valid_ff;
   logic              valid_in;
   tit_pkg::slot_type slot_ff;
   tit_pkg::slot_type slot_in;
   logic              take_up;
   logic              vacate;

   // Compaction is local: an empty cell pulls a valid upper neighbor down,
   // and a valid cell above an empty one gives its entry away.
   assign take_up = !valid_ff && up_valid;
   assign vacate  = valid_ff && !low_valid;
   assign gap     = take_up;

   always_comb begin
      valid_in = valid_ff;
      slot_in  = slot_ff;
      priority if (ctrl.write && wr_sel) begin
         valid_in = 1'b1;
         slot_in  = wr_slot;
      end else if (ctrl.shift) begin
         valid_in = up_valid;
         slot_in  = up_slot;
      end else if (ctrl.compact && take_up) begin
         valid_in = 1'b1;
         slot_in  = up_slot;
      end else if (ctrl.compact && vacate) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

   assign cur_valid = valid_ff;
   assign cur_slot  = slot_ff;

endmodule

@@ rtl/tit_chain.sv @@
// Row of timer cells: shifts toward cell 0 on a pass and closes gaps on compaction.
// Depends on tit_pkg and tit_cell.
module tit_chain #(
   parameter int NUM_SLOTS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  tit_pkg::chain_ctrl_type ctrl,
   input  logic [NUM_SLOTS-1:0]    wr_sel,
   input  tit_pkg::slot_type       wr_slot,
   input  logic                    tail_valid,
   input  tit_pkg::slot_type       tail_slot,
   output logic                    head_valid,
   output tit_pkg::slot_type       head_slot,
   output logic                    packed_done
);

   logic [NUM_SLOTS-1:0] cell_valid;
   tit_pkg::slot_type    cell_slot [NUM_SLOTS];
   logic [NUM_SLOTS-1:0] up_valid;
   tit_pkg::slot_type    up_slot [NUM_SLOTS];
   logic [NUM_SLOTS-1:0] low_valid;
   logic [NUM_SLOTS-1:0] gap;

   for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
      // Neighbor wiring: the top cell is fed from the head logic during a
      // pass and sees an empty neighbor during compaction.
      if (i == NUM_SLOTS - 1) begin : g_top
         assign up_valid[i] = ctrl.compact ? 1'b0 : tail_valid;
         assign up_slot[i]  = tail_slot;
      end else begin : g_mid
         assign up_valid[i] = cell_valid[i+1];
         assign up_slot[i]  = cell_slot[i+1];
      end
      if (i == 0) begin : g_bottom
         assign low_valid[i] = 1'b1;
      end else begin : g_upper
         assign low_valid[i] = cell_valid[i-1];
      end

      tit_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .wr_sel    (wr_sel[i]),
         .wr_slot   (wr_slot),
         .up_valid  (up_valid[i]),
         .up_slot   (up_slot[i]),
         .low_valid (low_valid[i]),
         .cur_valid (cell_valid[i]),
         .cur_slot  (cell_slot[i]),
         .gap       (gap[i])
      );
   end

   // The row is packed once no empty cell has a valid entry above it.
   assign packed_done = ~|gap;
   assign head_valid  = cell_valid[0];
   assign head_slot   = cell_slot[0];

endmodule

@@ rtl/timeout_interval_timer_table.sv @@
// Table of one-shot and periodic timers driven by a millisecond tick.
// Depends on tit_pkg and tit_chain.
//
// Usage: an input transaction on req_ carries a command. Schedule stores a new
// timer due at the current time plus duration_ms and returns its id (or a
// rejection when all NUM_SLOTS entries are in use). Clear removes the oldest
// entry with target_id and returns nothing. Tick advances time by one
// millisecond and returns one fired result per due entry, oldest first, at
// most 16 per tick. The last result of each command has last_of_run set.
// A clear or tick walks the row of cells once, each entry passing in turn
// through the single head unit, then closes the gaps left by removed entries,
// then hands over its last result. req_stall is high while a command is in
// progress. The result register lets the next command start while a result
// still waits. When the result register is full and rsp_stall holds, the walk
// pauses at a fired entry while an earlier fired result is still pending.
// Reset empties the table, sets time to zero and the next id to one.
module timeout_interval_timer_table #(
   parameter int NUM_SLOTS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  tit_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output tit_pkg::rsp_type rsp_data
);

   localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int CNT_W = $clog2(NUM_SLOTS + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(NUM_SLOTS);

   // Sequencer and bookkeeping registers.
   tit_pkg::state_type      state_ff;
   tit_pkg::state_type      state_in;
   logic [47:0]             now_ff;
   logic [47:0]             now_in;
   logic [31:0]             next_id_ff;
   logic [31:0]             next_id_in;
   logic [CNT_W-1:0]        count_ff;
   logic [CNT_W-1:0]        count_in;
   logic [IDX_W-1:0]        pass_cnt_ff;
   logic [IDX_W-1:0]        pass_cnt_in;
   logic                    clear_mode_ff;
   logic                    clear_mode_in;
   logic [31:0]             target_ff;
   logic [31:0]             target_in;
   logic                    found_ff;
   logic                    found_in;
   logic [tit_pkg::FIRE_W-1:0] fire_cnt_ff;
   logic [tit_pkg::FIRE_W-1:0] fire_cnt_in;

   // Pending result, held until it is known whether it is the last one.
   logic                    pend_valid_ff;
   logic                    pend_valid_in;
   logic [1:0]              pend_kind_ff;
   logic [1:0]              pend_kind_in;
   logic [31:0]             pend_id_ff;
   logic [31:0]             pend_id_in;

   // Result register.
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   tit_pkg::rsp_type        rsp_ff;
   tit_pkg::rsp_type        rsp_in;

   // Control signals.
   logic                    accept;
   logic                    out_free;
   logic                    head_due;
   logic                    tick_fire;
   logic                    clear_hit;
   logic                    step;
   logic                    pass_end;
   logic                    sched_ok;
   logic                    out_load;
   logic                    out_last;
   tit_pkg::chain_ctrl_type chain_ctrl;
   logic [NUM_SLOTS-1:0]    wr_sel;
   tit_pkg::slot_type       wr_slot;
   logic                    tail_valid;
   tit_pkg::slot_type       tail_slot;
   logic                    head_valid;
   tit_pkg::slot_type       head_slot;
   logic                    packed_done;

   tit_chain #(
      .NUM_SLOTS (NUM_SLOTS)
   ) u_chain (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (chain_ctrl),
      .wr_sel      (wr_sel),
      .wr_slot     (wr_slot),
      .tail_valid  (tail_valid),
      .tail_slot   (tail_slot),
      .head_valid  (head_valid),
      .head_slot   (head_slot),
      .packed_done (packed_done)
   );

   // Head unit: decides what happens to the entry leaving cell 0.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign head_due  = head_valid && (head_slot.due <= now_ff);
   assign tick_fire = !clear_mode_ff && head_due && (fire_cnt_ff < tit_pkg::MAX_RESULTS);
   assign clear_hit = clear_mode_ff && head_valid && !found_ff &&
                      (head_slot.ident == target_ff);

   always_comb begin
      tail_valid = head_valid;
      tail_slot  = head_slot;
      if (tick_fire) begin
         if (head_slot.periodic) begin
            tail_slot.due = head_slot.due + {16'd0, head_slot.period};
         end else begin
            tail_valid = 1'b0;
         end
      end else if (clear_hit) begin
         tail_valid = 1'b0;
      end
   end

   // Outputs of the sequencer.
   always_comb begin
      req_stall  = (state_ff != tit_pkg::ST_IDLE);
      accept     = req_valid && !req_stall;
      sched_ok   = (count_ff != FULL_CNT);
      step       = (state_ff == tit_pkg::ST_PASS) &&
                   !(tick_fire && pend_valid_ff && !out_free);
      pass_end   = step && (pass_cnt_ff == LAST_IDX);
      chain_ctrl.shift   = step;
      chain_ctrl.compact = (state_ff == tit_pkg::ST_COMPACT);
      chain_ctrl.write   = accept && (req_data.cmd == tit_pkg::CMD_SCHEDULE) && sched_ok;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         wr_sel[i] = (count_ff == CNT_W'(i));
      end
      wr_slot.ident    = next_id_ff;
      wr_slot.period   = req_data.duration_ms;
      wr_slot.due      = now_ff + {16'd0, req_data.duration_ms};
      wr_slot.periodic = req_data.repeat_flag;
      // A new fire pushes the held one out; the flush pushes the final one.
      out_load = 1'b0;
      out_last = 1'b0;
      if (step && tick_fire && pend_valid_ff) begin
         out_load = 1'b1;
      end else if ((state_ff == tit_pkg::ST_FLUSH) && pend_valid_ff && out_free) begin
         out_load = 1'b1;
         out_last = 1'b1;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tit_pkg::ST_IDLE: begin
            if (accept) begin
               unique case (req_data.cmd)
                  tit_pkg::CMD_SCHEDULE: state_in = tit_pkg::ST_FLUSH;
                  tit_pkg::CMD_CLEAR:    state_in = tit_pkg::ST_PASS;
                  tit_pkg::CMD_TICK:     state_in = tit_pkg::ST_PASS;
                  default:               state_in = tit_pkg::ST_IDLE;
               endcase
            end
         end
         tit_pkg::ST_PASS: begin
            if (pass_end) begin
               state_in = tit_pkg::ST_COMPACT;
            end
         end
         tit_pkg::ST_COMPACT: begin
            if (packed_done) begin
               state_in = tit_pkg::ST_FLUSH;
            end
         end
         tit_pkg::ST_FLUSH: begin
            if (!pend_valid_ff || out_free) begin
               state_in = tit_pkg::ST_IDLE;
            end
         end
         default: state_in = tit_pkg::ST_IDLE;
      endcase
   end

   // Datapath and bookkeeping updates.
   always_comb begin
      now_in        = now_ff;
      next_id_in    = next_id_ff;
      count_in      = count_ff;
      pass_cnt_in   = pass_cnt_ff;
      clear_mode_in = clear_mode_ff;
      target_in     = target_ff;
      found_in      = found_ff;
      fire_cnt_in   = fire_cnt_ff;
      pend_valid_in = pend_valid_ff;
      pend_kind_in  = pend_kind_ff;
      pend_id_in    = pend_id_ff;

      // Command start.
      if (accept) begin
         pass_cnt_in = '0;
         found_in    = 1'b0;
         fire_cnt_in = '0;
         unique case (req_data.cmd)
            tit_pkg::CMD_SCHEDULE: begin
               pend_valid_in = 1'b1;
               if (sched_ok) begin
                  pend_kind_in = tit_pkg::EVT_ASSIGNED;
                  pend_id_in   = next_id_ff;
                  next_id_in   = next_id_ff + 32'd1;
                  count_in     = count_ff + CNT_W'(1);
               end else begin
                  pend_kind_in = tit_pkg::EVT_REJECTED;
                  pend_id_in   = '0;
               end
            end
            tit_pkg::CMD_CLEAR: begin
               clear_mode_in = 1'b1;
               target_in     = req_data.target_id;
            end
            tit_pkg::CMD_TICK: begin
               clear_mode_in = 1'b0;
               now_in        = now_ff + 48'd1;
            end
            default: begin
               clear_mode_in = clear_mode_ff;
            end
         endcase
      end

      // One step of the walk through the row.
      if (step) begin
         pass_cnt_in = pass_cnt_ff + IDX_W'(1);
         if (tick_fire) begin
            pend_valid_in = 1'b1;
            pend_kind_in  = tit_pkg::EVT_FIRED;
            pend_id_in    = head_slot.ident;
            fire_cnt_in   = fire_cnt_ff + tit_pkg::FIRE_W'(1);
         end
         if (clear_hit) begin
            found_in = 1'b1;
         end
         if (head_valid && !tail_valid) begin
            count_in = count_ff - CNT_W'(1);
         end
      end

      // The final result leaves the pending register.
      if (out_load && out_last) begin
         pend_valid_in = 1'b0;
      end
   end

   // Result register update.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      if (out_load) begin
         rsp_valid_in       = 1'b1;
         rsp_in.event_kind  = pend_kind_ff;
         rsp_in.event_id    = pend_id_ff;
         rsp_in.last_of_run = out_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= tit_pkg::ST_IDLE;
         now_ff        <= '0;
         next_id_ff    <= 32'd1;
         count_ff      <= '0;
         pass_cnt_ff   <= '0;
         clear_mode_ff <= 1'b0;
         found_ff      <= 1'b0;
         fire_cnt_ff   <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         now_ff        <= now_in;
         next_id_ff    <= next_id_in;
         count_ff      <= count_in;
         pass_cnt_ff   <= pass_cnt_in;
         clear_mode_ff <= clear_mode_in;
         found_ff      <= found_in;
         fire_cnt_ff   <= fire_cnt_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      target_ff    <= target_in;
      pend_kind_ff <= pend_kind_in;
      pend_id_ff   <= pend_id_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
